>>> src/swrto_pkg.sv
// Shared types, codes and flag tables for the stop-and-wait sender.
// No dependencies; imported by the top level and the response checker.
package swrto_pkg;

    // Command codes on the input channel
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_RESP  = 2'd2
    } t_cmd;

    // Transfer kinds carried with a start command
    typedef enum logic [1:0] {
        KIND_OPEN  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_FINAL = 2'd2,
        KIND_CLOSE = 2'd3
    } t_kind;

    // Status reported with every result
    typedef enum logic [1:0] {
        STAT_IDLE    = 2'd0,
        STAT_WAIT    = 2'd1,
        STAT_DONE    = 2'd2,
        STAT_GAVE_UP = 2'd3
    } t_status;

    // Header and acknowledge flag bits
    localparam logic [7:0] FLAG_ACK   = 8'h01;
    localparam logic [7:0] FLAG_SYN   = 8'h02;
    localparam logic [7:0] FLAG_DATA  = 8'h04;
    localparam logic [7:0] FLAG_FINAL = 8'h08;
    localparam logic [7:0] FLAG_FIN   = 8'h10;

    localparam logic [15:0] CSUM_GOOD = 16'hFFFF;

    // Reset values of the estimator and the retry limit
    localparam int          EST_RESET   = 8000;
    localparam int          RTO_RESET   = 10000;
    localparam int          RTO_MIN_W   = 14;
    localparam logic [3:0]  LIMIT_RESET = 4'd10;
    localparam logic [3:0]  COUNT_MAX   = 4'd15;

    // Header flags to send for each kind (low five bits of the flag byte)
    function automatic logic [4:0] send_flags(input t_kind kind);
        logic [7:0] f;
        unique case (kind)
            KIND_OPEN:  f = FLAG_SYN;
            KIND_DATA:  f = FLAG_DATA;
            KIND_FINAL: f = FLAG_FINAL;
            KIND_CLOSE: f = FLAG_FIN;
            default:    f = FLAG_SYN;
        endcase
        return f[4:0];
    endfunction

    // Flag byte expected in the acknowledge for each kind
    function automatic logic [7:0] ack_flags(input t_kind kind);
        logic [7:0] f;
        unique case (kind)
            KIND_OPEN:  f = FLAG_SYN | FLAG_ACK;
            KIND_DATA:  f = FLAG_ACK;
            KIND_FINAL: f = FLAG_ACK;
            KIND_CLOSE: f = FLAG_FIN | FLAG_ACK;
            default:    f = FLAG_ACK;
        endcase
        return f;
    endfunction

endpackage

>>> src/swrto_resp_check.sv
// Response validation: ones' complement checksum, flag byte and sequence byte.
// Depends on swrto_pkg for the acknowledge flag table.
module swrto_resp_check (
    input  logic [47:0]          i_response,
    input  swrto_pkg::t_kind     i_kind,
    input  logic                 i_seq_bit,
    output logic                 o_ok
);
    import swrto_pkg::*;

    logic [17:0] sum_raw;
    logic [16:0] fold_one;
    logic [15:0] fold_two;
    logic [7:0]  flag_byte;
    logic [7:0]  seq_byte;

    // Sum the three words, then fold the carries back in twice
    always_comb begin
        sum_raw   = {2'b00, i_response[47:32]} + {2'b00, i_response[31:16]}
                  + {2'b00, i_response[15:0]};
        fold_one  = {1'b0, sum_raw[15:0]} + {15'd0, sum_raw[17:16]};
        fold_two  = fold_one[15:0] + {15'd0, fold_one[16]};
        flag_byte = i_response[31:24];
        seq_byte  = i_response[23:16];
        o_ok      = (fold_two == CSUM_GOOD) && (flag_byte == ack_flags(i_kind))
                  && (seq_byte == {7'd0, i_seq_bit});
    end

endmodule

>>> src/swrto_estimator.sv
// Jacobson round-trip estimator update: smoothed estimate x8, deviation x4, RTO.
// Self-contained; widths follow TIME_BITS. Saturates at every stage.
module swrto_estimator #(
    parameter int TIME_BITS = 20
) (
    input  logic [TIME_BITS-1:0] i_sample,
    input  logic [TIME_BITS+2:0] i_est_x8,
    input  logic [TIME_BITS+1:0] i_dev_x4,
    output logic [TIME_BITS+2:0] o_est_x8,
    output logic [TIME_BITS+1:0] o_dev_x4,
    output logic [TIME_BITS-1:0] o_rto
);
    localparam int EST_W = TIME_BITS + 3;
    localparam int DEV_W = TIME_BITS + 2;

    logic [EST_W:0]     est_sum;
    logic [TIME_BITS-1:0] est_whole;
    logic [TIME_BITS-1:0] diff;
    logic [DEV_W:0]     dev_sum;
    logic [DEV_W:0]     rto_sum;

    always_comb begin
        // Estimate: est - est/8 + sample
        est_sum  = {1'b0, i_est_x8 - (i_est_x8 >> 3)} + (EST_W+1)'(i_sample);
        o_est_x8 = est_sum[EST_W] ? '1 : est_sum[EST_W-1:0];
        est_whole = o_est_x8[EST_W-1:3];

        // Deviation: dev - dev/4 + |sample - est|
        diff = (i_sample >= est_whole) ? (i_sample - est_whole) : (est_whole - i_sample);
        dev_sum  = {1'b0, i_dev_x4 - (i_dev_x4 >> 2)} + (DEV_W+1)'(diff);
        o_dev_x4 = dev_sum[DEV_W] ? '1 : dev_sum[DEV_W-1:0];

        // Timeout: est + 4*dev, clipped to the tick range
        rto_sum = (DEV_W+1)'(est_whole) + {1'b0, o_dev_x4};
        o_rto   = (|rto_sum[DEV_W:TIME_BITS]) ? '1 : rto_sum[TIME_BITS-1:0];
    end

endmodule

>>> src/stop_and_wait_sender_rto_top.sv
// Stop-and-wait sender with Jacobson retransmission timeout.
// An input transfer reaches the result channel through the input register and the result
// register. Throughput: one item per cycle while the result side does not stall; each command
// updates the state in the cycle it leaves the input register, so the next item follows directly.
// Reset (synchronous, active low): idle, sequence bit 0, estimate 8000/8, RTO 10000, limit 10.
// Uses swrto_pkg, swrto_resp_check and swrto_estimator.
module stop_and_wait_sender_rto_top #(
    parameter int TIME_BITS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_cmd,
    input  logic [1:0]           i_kind,
    input  logic [47:0]          i_response,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_send_now,
    output logic [4:0]           o_header_flags,
    output logic                 o_header_seq,
    output logic [1:0]           o_status,
    output logic [TIME_BITS-1:0] o_timeout_now,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import swrto_pkg::*;

    localparam int EST_W = TIME_BITS + 3;
    localparam int DEV_W = TIME_BITS + 2;
    localparam int RTO_W = (TIME_BITS > RTO_MIN_W) ? TIME_BITS : RTO_MIN_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [2:0] ADDR_RETRY_LIMIT = 3'd0;

    // input register
    logic                 r_in_valid;
    logic [1:0]           r_in_cmd;
    t_kind                r_in_kind;
    logic [47:0]          r_in_response;

    // sender state
    logic                 r_seq_bit,    n_seq_bit;
    t_kind                r_active_kind, n_active_kind;
    logic                 r_waiting,    n_waiting;
    logic [TIME_BITS-1:0] r_elapsed,    n_elapsed;
    logic [3:0]           r_send_count, n_send_count;
    logic [3:0]           r_timeout_count, n_timeout_count;
    logic [EST_W-1:0]     r_est_x8,     n_est_x8;
    logic [DEV_W-1:0]     r_dev_x4,     n_dev_x4;
    logic [RTO_W-1:0]     r_rto,        n_rto;
    logic [3:0]           r_retry_limit;

    // result register
    logic                 r_out_valid;
    logic                 r_send_now,   n_send_now;
    logic [4:0]           r_header_flags, n_header_flags;
    logic                 r_header_seq, n_header_seq;
    t_status              r_status,     n_status;
    logic [TIME_BITS-1:0] r_timeout_now;

    logic                 out_free;
    logic                 advance;
    logic                 resp_ok;
    logic [TIME_BITS-1:0] elapsed_inc;
    logic [3:0]           send_inc;
    logic [3:0]           timeout_inc;
    logic                 give_up;
    logic [EST_W-1:0]     est_new;
    logic [DEV_W-1:0]     dev_new;
    logic [TIME_BITS-1:0] rto_new;

    // Handshake: the item in the input register moves on when the result slot is free
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    swrto_resp_check u_resp_check (
        .i_response (r_in_response),
        .i_kind     (r_active_kind),
        .i_seq_bit  (r_seq_bit),
        .o_ok       (resp_ok)
    );

    swrto_estimator #(
        .TIME_BITS (TIME_BITS)
    ) u_estimator (
        .i_sample (r_elapsed),
        .i_est_x8 (r_est_x8),
        .i_dev_x4 (r_dev_x4),
        .o_est_x8 (est_new),
        .o_dev_x4 (dev_new),
        .o_rto    (rto_new)
    );

    // Saturating increments
    assign elapsed_inc = (r_elapsed == TIME_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign send_inc    = (r_send_count == COUNT_MAX) ? r_send_count : r_send_count + 4'd1;
    assign timeout_inc = (r_timeout_count == COUNT_MAX) ? r_timeout_count
                                                        : r_timeout_count + 4'd1;

    // Give-up decision for a tick that times out
    always_comb begin
        case (r_active_kind) inside
            KIND_DATA, KIND_FINAL: give_up = (r_send_count >= r_retry_limit);
            KIND_CLOSE:            give_up = (timeout_inc >= r_retry_limit);
            default:               give_up = 1'b0;
        endcase
    end

    // Command decode: next state and result
    always_comb begin
        n_seq_bit       = r_seq_bit;
        n_active_kind   = r_active_kind;
        n_waiting       = r_waiting;
        n_elapsed       = r_elapsed;
        n_send_count    = r_send_count;
        n_timeout_count = r_timeout_count;
        n_est_x8        = r_est_x8;
        n_dev_x4        = r_dev_x4;
        n_rto           = r_rto;
        n_send_now      = 1'b0;
        n_header_flags  = 5'd0;
        n_header_seq    = 1'b0;
        n_status        = r_waiting ? STAT_WAIT : STAT_IDLE;

        unique case (r_in_cmd)
            CMD_START: begin
                n_active_kind   = r_in_kind;
                n_waiting       = 1'b1;
                n_elapsed       = '0;
                n_send_count    = 4'd1;
                n_timeout_count = 4'd0;
                n_send_now      = 1'b1;
                n_header_flags  = send_flags(r_in_kind);
                n_header_seq    = r_seq_bit;
                n_status        = STAT_WAIT;
            end
            CMD_TICK: begin
                if (r_waiting) begin
                    n_elapsed = elapsed_inc;
                    if (RTO_W'(elapsed_inc) > r_rto) begin
                        if (r_active_kind == KIND_CLOSE) begin
                            n_timeout_count = timeout_inc;
                        end
                        if (give_up) begin
                            n_waiting = 1'b0;
                            n_status  = STAT_GAVE_UP;
                        end else begin
                            n_elapsed      = '0;
                            n_send_count   = send_inc;
                            n_send_now     = 1'b1;
                            n_header_flags = send_flags(r_active_kind);
                            n_header_seq   = r_seq_bit;
                        end
                    end
                end
            end
            CMD_RESP: begin
                if (r_waiting) begin
                    if (resp_ok) begin
                        n_est_x8  = est_new;
                        n_dev_x4  = dev_new;
                        n_rto     = RTO_W'(rto_new);
                        n_seq_bit = !r_seq_bit;
                        n_waiting = 1'b0;
                        n_status  = STAT_DONE;
                    end else begin
                        // bad response: resend at once
                        n_elapsed      = '0;
                        n_send_count   = send_inc;
                        n_send_now     = 1'b1;
                        n_header_flags = send_flags(r_active_kind);
                        n_header_seq   = r_seq_bit;
                    end
                end
            end
            default: begin
                n_status = r_waiting ? STAT_WAIT : STAT_IDLE;
            end
        endcase
    end

    // Input register: take a transfer whenever the slot is empty or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in_cmd      <= i_cmd;
            r_in_kind     <= t_kind'(i_kind);
            r_in_response <= i_response;
        end
    end

    // Sender state: advance with each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_bit       <= 1'b0;
            r_active_kind   <= KIND_OPEN;
            r_waiting       <= 1'b0;
            r_elapsed       <= '0;
            r_send_count    <= 4'd0;
            r_timeout_count <= 4'd0;
            r_est_x8        <= EST_W'(EST_RESET);
            r_dev_x4        <= '0;
            r_rto           <= RTO_W'(RTO_RESET);
        end else if (advance) begin
            r_seq_bit       <= n_seq_bit;
            r_active_kind   <= n_active_kind;
            r_waiting       <= n_waiting;
            r_elapsed       <= n_elapsed;
            r_send_count    <= n_send_count;
            r_timeout_count <= n_timeout_count;
            r_est_x8        <= n_est_x8;
            r_dev_x4        <= n_dev_x4;
            r_rto           <= n_rto;
        end
    end

    // Result register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance;
        end
        if (advance) begin
            r_send_now     <= n_send_now;
            r_header_flags <= n_header_flags;
            r_header_seq   <= n_header_seq;
            r_status       <= n_status;
            r_timeout_now  <= n_rto[TIME_BITS-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_send_now     = r_send_now;
    assign o_header_flags = r_header_flags;
    assign o_header_seq   = r_header_seq;
    assign o_status       = r_status;
    assign o_timeout_now  = r_timeout_now;

    // Configuration register: write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_RETRY_LIMIT) begin
            r_retry_limit <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_RETRY_LIMIT) ? {28'd0, r_retry_limit} : 32'd0;

endmodule

>>> tb/stop_and_wait_sender_rto_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the stop-and-wait sender with retransmission timeout estimator.
// Drives commands, stalls results at random, writes the retry limit over APB and predicts
// every result; depends on swrto_pkg and stop_and_wait_sender_rto_top.
module stop_and_wait_sender_rto_top_tb;
    import swrto_pkg::*;

    localparam int              TB          = 20;
    localparam longint unsigned TICK_MAX    = (64'd1 << TB) - 1;
    localparam longint unsigned EST_MAX     = (64'd1 << (TB + 3)) - 1;
    localparam longint unsigned DEV_MAX     = (64'd1 << (TB + 2)) - 1;
    localparam logic [1:0]      CMD_NONE    = 2'd3;
    localparam logic [2:0]      REG_RETRY_LIMIT = 3'd0;
    localparam int unsigned     RANDOM_ITEMS = 1850;
    localparam int unsigned     PHASES      = 6;
    localparam int unsigned     CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [1:0]  cmd;
        t_kind       kind;
        logic [47:0] resp;
    } t_command;

    typedef struct {
        logic          send;
        logic [4:0]    flags;
        logic          seq;
        t_status       status;
        logic [TB-1:0] rto;
    } t_outcome;

    typedef struct {
        logic [3:0]    limit;
        logic          seq;
        t_kind         kind;
        logic          busy;
        logic [TB-1:0] elapsed;
        logic [3:0]    sends;
        logic [3:0]    timeouts;
        logic [TB+2:0] est_x8;
        logic [TB+1:0] dev_x4;
        logic [TB-1:0] rto;
    } t_sender;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_stall;
    logic [1:0]    i_cmd = CMD_TICK;
    logic [1:0]    i_kind = KIND_OPEN;
    logic [47:0]   i_response = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    logic          o_send_now;
    logic [4:0]    o_header_flags;
    logic          o_header_seq;
    logic [1:0]    o_status;
    logic [TB-1:0] o_timeout_now;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [2:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    t_command    pending[$];
    t_outcome    awaited_replies[$];
    t_sender     plan;
    t_sender     model;
    logic        in_fire = 1'b0;
    int unsigned in_gap = 0;
    int unsigned in_calm = 0;
    int unsigned out_hold = 0;
    int unsigned out_calm = 0;
    int unsigned cycle = 0;
    int unsigned errors = 0;
    int unsigned planned_work = 0;
    int unsigned n_items = 0;
    int unsigned n_results = 0;
    int unsigned n_done = 0;
    int unsigned n_gave_up = 0;
    int unsigned n_resends = 0;

    stop_and_wait_sender_rto_top #(.TIME_BITS(TB)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_kind         (i_kind),
        .i_response     (i_response),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_send_now     (o_send_now),
        .o_header_flags (o_header_flags),
        .o_header_seq   (o_header_seq),
        .o_status       (o_status),
        .o_timeout_now  (o_timeout_now),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Free-running clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want, got);
        if (got !== want) flag_error($sformatf("%s expected %0h got %0h", name, want, got));
    endfunction

    function automatic t_sender sender_reset();
        t_sender s;
        s.limit    = LIMIT_RESET;
        s.seq      = 1'b0;
        s.kind     = KIND_OPEN;
        s.busy     = 1'b0;
        s.elapsed  = '0;
        s.sends    = '0;
        s.timeouts = '0;
        s.est_x8   = (TB+3)'(EST_RESET);
        s.dev_x4   = '0;
        s.rto      = TB'(RTO_RESET);
        return s;
    endfunction

    // Ones' complement sum of three words with end-around carry
    function automatic logic [15:0] csum_fold(input logic [15:0] a, b, c);
        logic [17:0] s;
        s = 18'(a) + 18'(b) + 18'(c);
        s = 18'(s[15:0]) + 18'(s[17:16]);
        s = 18'(s[15:0]) + 18'(s[17:16]);
        return s[15:0];
    endfunction

    function automatic logic [4:0] hdr_flags(input t_kind kind);
        logic [7:0] f;
        case (kind)
            KIND_OPEN:  f = FLAG_SYN;
            KIND_DATA:  f = FLAG_DATA;
            KIND_FINAL: f = FLAG_FINAL;
            default:    f = FLAG_FIN;
        endcase
        return f[4:0];
    endfunction

    function automatic logic [7:0] ack_flag(input t_kind kind);
        logic [7:0] f;
        case (kind)
            KIND_OPEN:  f = FLAG_SYN | FLAG_ACK;
            KIND_CLOSE: f = FLAG_FIN | FLAG_ACK;
            default:    f = FLAG_ACK;
        endcase
        return f;
    endfunction

    // Emit the current header again and restart the timer
    function automatic void retransmit(inout t_sender s, inout t_outcome r);
        r.send    = 1'b1;
        r.flags   = hdr_flags(s.kind);
        r.seq     = s.seq;
        s.elapsed = '0;
        if (s.sends != COUNT_MAX) s.sends = s.sends + 4'd1;
    endfunction

    // Advance the sender by one command and return the result it reports
    function automatic t_outcome sender_step(inout t_sender s, input t_command c);
        t_outcome        r;
        logic            give_up;
        longint unsigned e, est, diff, d, sum;
        r.send   = 1'b0;
        r.flags  = '0;
        r.seq    = 1'b0;
        r.status = s.busy ? STAT_WAIT : STAT_IDLE;
        if (c.cmd == CMD_START) begin
            s.kind     = c.kind;
            s.busy     = 1'b1;
            s.elapsed  = '0;
            s.sends    = 4'd1;
            s.timeouts = '0;
            r.send     = 1'b1;
            r.flags    = hdr_flags(c.kind);
            r.seq      = s.seq;
            r.status   = STAT_WAIT;
        end else if (c.cmd == CMD_TICK && s.busy) begin
            if (s.elapsed != '1) s.elapsed = s.elapsed + 1'b1;
            if (s.elapsed > s.rto) begin
                give_up = 1'b0;
                if (s.kind == KIND_DATA || s.kind == KIND_FINAL) begin
                    give_up = (s.sends >= s.limit);
                end else if (s.kind == KIND_CLOSE) begin
                    if (s.timeouts != COUNT_MAX) s.timeouts = s.timeouts + 4'd1;
                    give_up = (s.timeouts >= s.limit);
                end
                if (give_up) begin
                    s.busy   = 1'b0;
                    r.status = STAT_GAVE_UP;
                end else begin
                    retransmit(s, r);
                end
            end
        end else if (c.cmd == CMD_RESP && s.busy) begin
            if (csum_fold(c.resp[47:32], c.resp[31:16], c.resp[15:0]) == CSUM_GOOD
                    && c.resp[31:24] == ack_flag(s.kind)
                    && c.resp[23:16] == {7'd0, s.seq}) begin
                // Jacobson update: smoothed estimate x8, deviation x4
                e = s.est_x8 - (s.est_x8 >> 3) + s.elapsed;
                if (e > EST_MAX) e = EST_MAX;
                s.est_x8 = e[TB+2:0];
                est  = e >> 3;
                diff = (s.elapsed >= est) ? s.elapsed - est : est - s.elapsed;
                d    = s.dev_x4 - (s.dev_x4 >> 2) + diff;
                if (d > DEV_MAX) d = DEV_MAX;
                s.dev_x4 = d[TB+1:0];
                sum  = est + d;
                if (sum > TICK_MAX) sum = TICK_MAX;
                s.rto    = sum[TB-1:0];
                s.seq    = ~s.seq;
                s.busy   = 1'b0;
                r.status = STAT_DONE;
            end else begin
                retransmit(s, r);
            end
        end
        r.rto = s.rto;
        return r;
    endfunction

    // Response with a correct checksum over the given flags, sequence and length
    function automatic logic [47:0] build_resp(input logic [7:0] flags, seqb,
                                               input logic [15:0] len);
        return {~csum_fold(16'h0000, {flags, seqb}, len), flags, seqb, len};
    endfunction

    function automatic logic [47:0] good_ack();
        return build_resp(ack_flag(plan.kind), {7'd0, plan.seq}, 16'($urandom));
    endfunction

    function automatic logic [47:0] any_resp();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // A response that is broken in one way or another
    function automatic logic [47:0] bad_ack();
        logic [7:0]  f;
        logic [47:0] r;
        case ($urandom_range(4))
            0: r = good_ack() ^ (48'd1 << $urandom_range(47));
            1: begin
                f = 8'($urandom);
                if (f == ack_flag(plan.kind)) f = f ^ 8'h10;
                r = build_resp(f, {7'd0, plan.seq}, 16'($urandom));
            end
            2: begin
                f = 8'($urandom);
                if (f == {7'd0, plan.seq}) f = f ^ 8'h01;
                r = build_resp(ack_flag(plan.kind), f, 16'($urandom));
            end
            3: r = any_resp();
            default: r = ($urandom_range(1) != 0) ? '1 : '0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] stray_cmd();
        logic [1:0] c;
        case ($urandom_range(2))
            0:       c = CMD_TICK;
            1:       c = CMD_RESP;
            default: c = CMD_NONE;
        endcase
        return c;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a calm stretch with none
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned p;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        p = $urandom_range(999);
        if (p < 10) begin
            calm = $urandom_range(40, 150);
            return 0;
        end
        if (p < 550) return 0;
        if (p < 880) return $urandom_range(1, 2);
        if (p < 980) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Queue a command and keep the planning copy of the sender in step
    function automatic t_outcome enqueue(input logic [1:0] cmd, input t_kind kind,
                                         input logic [47:0] resp);
        t_command c;
        t_outcome o;
        c.cmd  = cmd;
        c.kind = kind;
        c.resp = resp;
        pending.insert(pending.size(), c);
        o = sender_step(plan, c);
        if (o.status != STAT_IDLE) planned_work++;
        return o;
    endfunction

    // Transfers with random content: mostly well-formed exchanges, some broken, some noise
    task automatic random_block(input int unsigned target);
        int unsigned goal, n, k, mode;
        goal = planned_work + target;
        while (planned_work < goal) begin
            if ($urandom_range(19) == 0)
                void'(enqueue(stray_cmd(), t_kind'($urandom_range(3)), any_resp()));
            void'(enqueue(CMD_START, t_kind'($urandom_range(3)), any_resp()));
            mode = $urandom_range(99);
            if (mode >= 93) begin
                // abandon: a stray command, then the next start drops this transfer
                void'(enqueue(stray_cmd(), t_kind'($urandom_range(3)), any_resp()));
            end else if (mode >= 75 && plan.rto <= 40) begin
                // tick through resends until the timer gives up or 250 ticks have been queued
                k = 0;
                while (plan.busy && k < 250) begin
                    void'(enqueue(CMD_TICK, t_kind'($urandom_range(3)), any_resp()));
                    k++;
                end
                if (plan.busy) void'(enqueue(CMD_RESP, plan.kind, good_ack()));
            end else if (mode >= 55 && mode < 75) begin
                n = ($urandom_range(19) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 4);
                for (k = 0; k < n; k++) begin
                    if (plan.busy && $urandom_range(3) == 0)
                        void'(enqueue(CMD_TICK, t_kind'($urandom_range(3)), any_resp()));
                    if (plan.busy)
                        void'(enqueue(CMD_RESP, t_kind'($urandom_range(3)), bad_ack()));
                end
                if (plan.busy) void'(enqueue(CMD_RESP, plan.kind, good_ack()));
            end else begin
                n = ($urandom_range(99) < 85) ? $urandom_range(3) : $urandom_range(4, 40);
                for (k = 0; k < n; k++) begin
                    if (plan.busy)
                        void'(enqueue(CMD_TICK, t_kind'($urandom_range(3)), any_resp()));
                end
                if (plan.busy && $urandom_range(9) != 0)
                    void'(enqueue(CMD_RESP, t_kind'($urandom_range(3)), good_ack()));
            end
        end
    endtask

    // Hold until every queued command is taken and every result is back;
    // look just after the falling edge so the driver's updates have settled
    task automatic wait_quiet();
        @(negedge i_clk);
        #1;
        while (pending.size() != 0 || i_in_valid || awaited_replies.size() != 0) begin
            @(negedge i_clk);
            #1;
        end
    endtask

    // APB write of the retry limit, then read it back
    task automatic set_retry_limit(input logic [3:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_RETRY_LIMIT;
        pwdata  <= {28'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_field("retry_limit readback", 64'(v), 64'(prdata[3:0]));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        plan.limit  = v;
        model.limit = v;
    endtask

    // Present the next command; hold it while stalled, then leave a random gap
    always @(negedge i_clk) begin : feed
        t_command cur;
        if (!i_in_valid || in_fire) begin
            if (in_gap != 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending.size() != 0) begin
                cur = pending.pop_front();
                i_cmd      <= cur.cmd;
                i_kind     <= cur.kind;
                i_response <= cur.resp;
                i_in_valid <= 1'b1;
                in_gap = pick_gap(in_calm);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random
    always @(negedge i_clk) begin : result_stall
        if (out_hold != 0) begin
            i_out_stall <= 1'b1;
            out_hold--;
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(2) == 0) out_hold = pick_gap(out_calm);
        end
    end

    // Check each result transfer, then predict from each command transfer
    always @(posedge i_clk) begin : watch
        t_command seen;
        t_outcome want;
        cycle++;
        in_fire <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (awaited_replies.size() == 0) begin
                flag_error("result transfer with nothing outstanding");
            end else begin
                want = awaited_replies.pop_front();
                check_field("send_now", 64'(want.send), 64'(o_send_now));
                check_field("header_flags", 64'(want.flags), 64'(o_header_flags));
                check_field("header_seq", 64'(want.seq), 64'(o_header_seq));
                check_field("status", 64'(want.status), 64'(o_status));
                check_field("timeout_now", 64'(want.rto), 64'(o_timeout_now));
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            seen.cmd  = i_cmd;
            seen.kind = t_kind'(i_kind);
            seen.resp = i_response;
            want = sender_step(model, seen);
            awaited_replies.insert(awaited_replies.size(), want);
            n_items++;
            if (want.status == STAT_DONE) n_done++;
            if (want.status == STAT_GAVE_UP) n_gave_up++;
            if (want.send && seen.cmd != CMD_START) n_resends++;
        end
    end

    // Give up on a hung run
    initial begin : watchdog
        wait (cycle >= CYCLE_LIMIT);
        $display("run stopped after %0d cycles with %0d results outstanding",
                 cycle, awaited_replies.size());
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned k;
        logic [3:0]  lim;
        plan  = sender_reset();
        model = sender_reset();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle commands, every kind, broken responses, restart while waiting
        void'(enqueue(CMD_TICK, KIND_CLOSE, '1));
        void'(enqueue(CMD_RESP, KIND_OPEN, '0));
        void'(enqueue(CMD_NONE, KIND_DATA, '1));
        void'(enqueue(CMD_START, KIND_OPEN, '0));
        void'(enqueue(CMD_TICK, KIND_OPEN, '0));
        void'(enqueue(CMD_NONE, KIND_OPEN, '0));
        void'(enqueue(CMD_RESP, KIND_OPEN, '1));
        void'(enqueue(CMD_RESP, KIND_OPEN, build_resp(ack_flag(KIND_OPEN), 8'd1, 16'hFFFF)));
        void'(enqueue(CMD_RESP, KIND_OPEN, build_resp(ack_flag(KIND_DATA), 8'd0, 16'h0000)));
        void'(enqueue(CMD_RESP, KIND_OPEN, good_ack() ^ 48'h0001_0000_0000));
        void'(enqueue(CMD_TICK, KIND_OPEN, '0));
        void'(enqueue(CMD_RESP, KIND_OPEN, good_ack()));
        void'(enqueue(CMD_START, KIND_DATA, '1));
        void'(enqueue(CMD_RESP, KIND_DATA, good_ack() ^ 48'h0000_0001_0000));
        void'(enqueue(CMD_START, KIND_FINAL, '0));
        void'(enqueue(CMD_RESP, KIND_FINAL, good_ack()));
        void'(enqueue(CMD_START, KIND_CLOSE, '1));
        void'(enqueue(CMD_TICK, KIND_CLOSE, '1));
        void'(enqueue(CMD_TICK, KIND_CLOSE, '0));
        void'(enqueue(CMD_RESP, KIND_CLOSE, good_ack()));
        void'(enqueue(CMD_TICK, KIND_DATA, '0));
        random_block(RANDOM_ITEMS / PHASES);

        // Further phases, each under a new retry limit written once all commands and results have drained
        for (k = 0; k < PHASES - 1; k++) begin
            wait_quiet();
            case (k)
                0:       lim = 4'd1;
                1:       lim = 4'd15;
                2:       lim = 4'd0;
                3:       lim = 4'($urandom_range(2, 14));
                default: lim = 4'($urandom_range(15));
            endcase
            set_retry_limit(lim);
            random_block(RANDOM_ITEMS / PHASES);
        end

        wait_quiet();
        repeat (6) @(negedge i_clk);
        $display("%0d commands, %0d results checked: %0d acknowledged, %0d resends, %0d give-ups",
                 n_items, n_results, n_done, n_resends, n_gave_up);
        $display("retry limits 10, 1, 15, 0 and two random values; %0d mismatches", errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
